>>> rtl/ped_pkg.sv
// Shared constants, codes and helpers for the priority event dispatcher.
package ped_pkg;

   localparam int NUM_EVENTS         = 8;
   localparam int HANDLERS_PER_EVENT = 4;
   localparam int HANDLER_ID_BITS    = 8;

   // Fixed field widths of the request and response beats.
   localparam int OPCODE_BITS      = 2;
   localparam int EVENT_BITS       = 3;
   localparam int ID_FIELD_BITS    = 8;
   localparam int STATUS_BITS      = 3;

   localparam int EV_IDX_BITS   = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
   localparam int COUNT_BITS    = $clog2(HANDLERS_PER_EVENT + 1);
   localparam int TBL_DEPTH     = NUM_EVENTS * HANDLERS_PER_EVENT;
   localparam int TBL_ADDR_BITS = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
   // Stored IDs keep only the bits that both the field and the ID width allow.
   localparam int ID_STORE_BITS =
      (HANDLER_ID_BITS < ID_FIELD_BITS) ? HANDLER_ID_BITS : ID_FIELD_BITS;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_SIGNAL = 2'd0,
      OP_ADD    = 2'd1,
      OP_HANDLE = 2'd2
   } opcode_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_ACCEPTED = 3'd0,
      ST_OVERRUN  = 3'd1,
      ST_ADDED    = 3'd2,
      ST_FULL     = 3'd3,
      ST_DISPATCH = 3'd4,
      ST_CLEARED  = 3'd5,
      ST_NONE     = 3'd6
   } status_type;

   typedef struct packed {
      logic dispatching;
      logic tbl_we;
   } ped_stat_type;

   function automatic logic [TBL_ADDR_BITS-1:0] tbl_addr(
      input logic [EV_IDX_BITS-1:0] ev,
      input logic [COUNT_BITS-1:0]  slot
   );
      return TBL_ADDR_BITS'(int'(ev) * HANDLERS_PER_EVENT + int'(slot));
   endfunction

endpackage

>>> rtl/ped_if.sv
// Request and response channel interfaces of the priority event dispatcher.
interface ped_req_if;
   logic                                valid;
   logic                                ready;
   logic [ped_pkg::OPCODE_BITS-1:0]     opcode;
   logic [ped_pkg::EVENT_BITS-1:0]      event_num;
   logic [ped_pkg::ID_FIELD_BITS-1:0]   handler_id;

   modport source (output valid, opcode, event_num, handler_id, input ready);
   modport sink   (input valid, opcode, event_num, handler_id, output ready);
endinterface

interface ped_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [ped_pkg::STATUS_BITS-1:0]     status;
   logic [ped_pkg::EVENT_BITS-1:0]      event_out;
   logic [ped_pkg::ID_FIELD_BITS-1:0]   handler_out;
   logic                                last;

   modport source (output valid, status, event_out, handler_out, last, input ready);
   modport sink   (input valid, status, event_out, handler_out, last, output ready);
endinterface

>>> rtl/ped_ram.sv
// Generic single-port synchronous RAM with a registered read.
module ped_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                         clock,
   input  logic                                         we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                             wdata,
   output logic [WIDTH-1:0]                             rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/ped_core.sv
// Sequencer holding the pending mask and handler counts, driving the handler table RAM.
module ped_core (
   input  logic                                 clock,
   input  logic                                 reset,
   ped_req_if.sink                              req,
   ped_rsp_if.source                            rsp,
   output logic                                 tbl_we,
   output logic [ped_pkg::TBL_ADDR_BITS-1:0]    tbl_addr,
   output logic [ped_pkg::ID_STORE_BITS-1:0]    tbl_wdata,
   input  logic [ped_pkg::ID_STORE_BITS-1:0]    tbl_rdata,
   output ped_pkg::ped_stat_type                stat
);

   typedef enum logic {
      S_IDLE,
      S_DISP
   } state_type;

   state_type                             state_ff, state_in;
   logic [ped_pkg::NUM_EVENTS-1:0]        pending_ff, pending_in;
   logic [ped_pkg::COUNT_BITS-1:0]        count_ff [ped_pkg::NUM_EVENTS];
   logic [ped_pkg::COUNT_BITS-1:0]        count_in [ped_pkg::NUM_EVENTS];
   logic [ped_pkg::EV_IDX_BITS-1:0]       ev_ff, ev_in;
   logic [ped_pkg::COUNT_BITS-1:0]        n_ff, n_in;
   logic [ped_pkg::COUNT_BITS-1:0]        slot_ff, slot_in;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [ped_pkg::STATUS_BITS-1:0]       status_ff, status_in;
   logic [ped_pkg::EVENT_BITS-1:0]        event_ff, event_in;
   logic [ped_pkg::ID_FIELD_BITS-1:0]     handler_ff, handler_in;
   logic                                  last_ff, last_in;

   logic                                  out_free;
   logic                                  accept;
   logic                                  ev_ok;
   logic [ped_pkg::EV_IDX_BITS-1:0]       ev_idx;
   logic                                  found;
   logic [ped_pkg::EV_IDX_BITS-1:0]       first_idx;
   logic [ped_pkg::EV_IDX_BITS-1:0]       sel_ev;
   logic [ped_pkg::COUNT_BITS-1:0]        sel_cnt;
   logic [ped_pkg::COUNT_BITS-1:0]        slot_next;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE) && out_free;
   assign accept = req.valid && req.ready;

   assign ev_ok  = int'(req.event_num) < ped_pkg::NUM_EVENTS;
   assign ev_idx = req.event_num[ped_pkg::EV_IDX_BITS-1:0];

   // Lowest-numbered pending event wins.
   always_comb begin
      found     = 1'b0;
      first_idx = '0;
      for (int i = ped_pkg::NUM_EVENTS - 1; i >= 0; i--) begin
         if (pending_ff[i]) begin
            found     = 1'b1;
            first_idx = ped_pkg::EV_IDX_BITS'(i);
         end
      end
   end

   assign sel_ev    = (req.opcode == ped_pkg::OP_HANDLE) ? first_idx : ev_idx;
   assign sel_cnt   = count_ff[sel_ev];
   assign slot_next = slot_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      pending_in   = pending_ff;
      count_in     = count_ff;
      ev_in        = ev_ff;
      n_in         = n_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      status_in    = status_ff;
      event_in     = event_ff;
      handler_in   = handler_ff;
      last_in      = last_ff;
      tbl_we       = 1'b0;
      tbl_wdata    = req.handler_id[ped_pkg::ID_STORE_BITS-1:0];
      // By default the current slot is read again, so a stalled entry stays in rdata.
      tbl_addr     = ped_pkg::tbl_addr(ev_ff, slot_ff);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               handler_in = '0;
               last_in    = 1'b1;
               event_in   = req.event_num;
               case (req.opcode)
                  ped_pkg::OP_SIGNAL: begin
                     rsp_valid_in = 1'b1;
                     if (!ev_ok || pending_ff[ev_idx]) begin
                        status_in = ped_pkg::ST_OVERRUN;
                     end else begin
                        pending_in[ev_idx] = 1'b1;
                        status_in          = ped_pkg::ST_ACCEPTED;
                     end
                  end
                  ped_pkg::OP_ADD: begin
                     rsp_valid_in = 1'b1;
                     if (!ev_ok || int'(sel_cnt) >= ped_pkg::HANDLERS_PER_EVENT) begin
                        status_in = ped_pkg::ST_FULL;
                     end else begin
                        tbl_we           = 1'b1;
                        tbl_addr         = ped_pkg::tbl_addr(ev_idx, sel_cnt);
                        count_in[ev_idx] = sel_cnt + 1'b1;
                        status_in        = ped_pkg::ST_ADDED;
                     end
                  end
                  ped_pkg::OP_HANDLE: begin
                     if (!found) begin
                        rsp_valid_in = 1'b1;
                        status_in    = ped_pkg::ST_NONE;
                        event_in     = '0;
                     end else begin
                        pending_in[first_idx] = 1'b0;
                        event_in              = ped_pkg::EVENT_BITS'(first_idx);
                        if (sel_cnt == '0) begin
                           rsp_valid_in = 1'b1;
                           status_in    = ped_pkg::ST_CLEARED;
                        end else begin
                           ev_in    = first_idx;
                           n_in     = sel_cnt;
                           slot_in  = '0;
                           tbl_addr = ped_pkg::tbl_addr(first_idx, '0);
                           state_in = S_DISP;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DISP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               status_in    = ped_pkg::ST_DISPATCH;
               event_in     = ped_pkg::EVENT_BITS'(ev_ff);
               handler_in   = ped_pkg::ID_FIELD_BITS'(tbl_rdata);
               last_in      = (slot_next == n_ff);
               if (slot_next == n_ff) begin
                  state_in = S_IDLE;
               end else begin
                  slot_in  = slot_next;
                  tbl_addr = ped_pkg::tbl_addr(ev_ff, slot_next);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pending_ff   <= '0;
         count_ff     <= '{default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ev_ff      <= ev_in;
      n_ff       <= n_in;
      slot_ff    <= slot_in;
      status_ff  <= status_in;
      event_ff   <= event_in;
      handler_ff <= handler_in;
      last_ff    <= last_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = status_ff;
   assign rsp.event_out   = event_ff;
   assign rsp.handler_out = handler_ff;
   assign rsp.last        = last_ff;

   assign stat.dispatching = (state_ff == S_DISP);
   assign stat.tbl_we      = tbl_we;

endmodule

>>> rtl/priority_event_dispatcher.sv
// Top level of the priority event dispatcher: sequencer, handler table RAM and checks.
// Signal and add beats each answer with one response beat; a new request
// beat is taken in the same cycle that the previous response beat leaves, so such beats
// stream at one per cycle while the response side keeps up. A handle beat that finds an
// event with n registered handlers walks them in order: the handler table sits in a
// single-port RAM that delivers one entry per cycle while the response side keeps up,
// and each entry becomes one dispatch response beat, the final one flagged with last.
// Handle with nothing pending, or with an event that has no handlers, answers with a
// single response beat. The handler table is not cleared after reset; only entries below
// an event's handler count are ever read. Unused opcodes are consumed without a response.
module priority_event_dispatcher (
   input  logic        clock,
   input  logic        reset,
   ped_req_if.sink     req,
   ped_rsp_if.source   rsp
);

   logic                                 tbl_we;
   logic [ped_pkg::TBL_ADDR_BITS-1:0]    tbl_addr;
   logic [ped_pkg::ID_STORE_BITS-1:0]    tbl_wdata;
   logic [ped_pkg::ID_STORE_BITS-1:0]    tbl_rdata;
   ped_pkg::ped_stat_type                stat;

   ped_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .tbl_we    (tbl_we),
      .tbl_addr  (tbl_addr),
      .tbl_wdata (tbl_wdata),
      .tbl_rdata (tbl_rdata),
      .stat      (stat)
   );

   ped_ram #(
      .WIDTH (ped_pkg::ID_STORE_BITS),
      .DEPTH (ped_pkg::TBL_DEPTH)
   ) u_tbl_ram (
      .clock (clock),
      .we    (tbl_we),
      .addr  (tbl_addr),
      .wdata (tbl_wdata),
      .rdata (tbl_rdata)
   );

   // No new request is taken while a handler list is being walked.
   a_no_accept_in_dispatch: assert property (@(posedge clock) disable iff (reset)
      stat.dispatching |-> !req.ready)
      else $error("request taken during dispatch");

   // The table is never written while its entries are being read out.
   a_no_write_in_dispatch: assert property (@(posedge clock) disable iff (reset)
      stat.tbl_we |-> !stat.dispatching)
      else $error("handler table written during dispatch");

   // Every response other than a dispatch closes its request.
   a_single_beat_last: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.status != ped_pkg::ST_DISPATCH)) |-> rsp.last)
      else $error("non-dispatch response without last");

   // A dispatch beat that is not last is followed by more of the same walk.
   a_walk_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && (rsp.status == ped_pkg::ST_DISPATCH) && !rsp.last)
      |-> stat.dispatching)
      else $error("dispatch walk ended before last beat");

endmodule
